[rtl/nas_pkg.sv]
// Shared types and constants of the neighbor address set.
// Used by nas_cell, neighbor_address_set_core and nas_checker; no dependencies.
package nas_pkg;

	localparam int ENTRIES = 8;
	localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ADDR_W  = 32;

	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [2:0] ST_ADDED     = 3'd0;
	localparam logic [2:0] ST_REMOVED   = 3'd1;
	localparam logic [2:0] ST_PRESENT   = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef struct packed {
		logic              command;
		logic [ADDR_W-1:0] address;
	} in_word_t;

	typedef struct packed {
		logic       success;
		logic [2:0] status;
		logic [2:0] slot;
	} out_word_t;

	// Token that walks down the chain of cells, gathering the search results.
	typedef struct packed {
		logic              vld;
		logic              command;
		logic [ADDR_W-1:0] address;
		logic              found;
		logic              have_free;
		slot_t             free_slot;
		logic              removed;
		slot_t             rem_slot;
	} token_t;

endpackage

[rtl/neighbor_address_set_core.sv]
// Top level of the neighbor address set: a chain of nas_cell entries and the result stage.
// Depends on nas_pkg and nas_cell.
//
// Usage: the input channel (in_valid, in_ready, in_data) carries one word with a
// command (add or remove) and a 32-bit address. The output channel (out_valid,
// out_ready, out_data) returns one word per input word: success, status and slot.
// An accepted word enters cell 0 and moves one cell per cycle down a chain of
// ENTRIES cells, each holding one table entry. A remove clears the first matching
// entry as it passes; an add is decided at the end of the chain and written into
// the highest free entry in the cycle the result is registered.
// The core takes a new word only once the previous one has left the chain;
// in_ready is high whenever no word is in the chain.
// When the receiver stalls, the finished result waits in the output register and a
// following word may enter the chain; it then holds in the last cell until the
// output register is free.
// Reset clears all valid marks, the chain and the output valid flag.
module neighbor_address_set_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  nas_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output nas_pkg::out_word_t  out_data
);
	import nas_pkg::*;

	token_t            tok_in;
	token_t            tok [ENTRIES];
	token_t            last;
	logic              busy_q;
	logic              out_valid_q;
	out_word_t         out_q;
	out_word_t         result;
	logic              finish;
	logic              add_ok;
	logic [ENTRIES-1:0] wr_en;

	assign in_ready = !busy_q;

	always_comb begin
		tok_in           = '0;
		tok_in.vld       = in_valid && in_ready;
		tok_in.command   = in_data.command;
		tok_in.address   = in_data.address;
	end

	genvar i;
	generate
		for (i = 0; i < ENTRIES; i++) begin : g_cell
			token_t cell_in;
			if (i == 0) begin : g_first
				assign cell_in = tok_in;
			end else begin : g_next
				assign cell_in = tok[i-1];
			end
			nas_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.index      (SLOT_W'(i)),
				.tok_i      (cell_in),
				.hold       ((i == ENTRIES - 1) && last.vld && !finish),
				.wr_en      (wr_en[i]),
				.wr_address (last.address),
				.tok_o      (tok[i])
			);
			assign wr_en[i] = finish && add_ok && (last.free_slot == SLOT_W'(i));
		end
	endgenerate

	assign last   = tok[ENTRIES-1];
	assign finish = last.vld && (!out_valid_q || out_ready);
	assign add_ok = (last.command == CMD_ADD) && !last.found && last.have_free;

	always_comb begin
		result = '0;
		if (last.command == CMD_ADD) begin
			if (last.found) begin
				result.status = ST_PRESENT;
			end else if (!last.have_free) begin
				result.status = ST_FULL;
			end else begin
				result.success = 1'b1;
				result.status  = ST_ADDED;
				result.slot    = 3'(last.free_slot);
			end
		end else if (last.removed) begin
			result.success = 1'b1;
			result.status  = ST_REMOVED;
			result.slot    = 3'(last.rem_slot);
		end else begin
			result.status = ST_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tok_in.vld) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[rtl/nas_cell.sv]
// One table entry of the neighbor address set and its stage of the token chain.
// Depends on nas_pkg.
module nas_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nas_pkg::slot_t        index,
	input  nas_pkg::token_t       tok_i,
	input  logic                  hold,
	input  logic                  wr_en,
	input  logic [31:0]           wr_address,
	output nas_pkg::token_t       tok_o
);
	import nas_pkg::*;

	logic              valid_q;
	logic [ADDR_W-1:0] address_q;
	token_t            tok_q;
	token_t            tok_nxt;
	logic              match;
	logic              clear;

	assign match = valid_q && (address_q == tok_i.address);

	always_comb begin
		tok_nxt = tok_i;
		clear   = 1'b0;
		if (tok_i.vld) begin
			if (tok_i.command == CMD_ADD) begin
				// Later cells overwrite, so the highest free slot wins.
				if (!valid_q) begin
					tok_nxt.have_free = 1'b1;
					tok_nxt.free_slot = index;
				end else if (match) begin
					tok_nxt.found = 1'b1;
				end
			end else if (match && !tok_i.removed) begin
				tok_nxt.removed  = 1'b1;
				tok_nxt.rem_slot = index;
				clear            = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
		end else if (clear) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			address_q <= wr_address;
		end else if (clear) begin
			address_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (!hold) begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_o = tok_q;

endmodule

[rtl/nas_checker.sv]
// Port-level checks for neighbor_address_set_core, attached by the bind below.
// Depends on nas_pkg.
module nas_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                out_valid,
	input  logic                out_ready,
	input  nas_pkg::out_word_t  out_data
);
	import nas_pkg::*;

	// A stalled result word keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// Only one word walks the chain at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word accepted while the chain is busy");

	a_success_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.success ==
			(out_data.status == ST_ADDED || out_data.status == ST_REMOVED)))
		else $error("success flag disagrees with status");

	a_idle_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.success |-> out_data.slot == 3'd0)
		else $error("slot reported although nothing changed");

endmodule

bind neighbor_address_set_core nas_checker u_nas_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

[tb/sv/tb_neighbor_address_set_core.sv]
// Self-checking testbench for neighbor_address_set_core: add/remove words against a model of the table.
// Depends on nas_pkg and the RTL of the core; drives random gaps and stalls on both channels.
`timescale 1ns / 1ps

module tb_neighbor_address_set_core;
	import nas_pkg::*;

	typedef struct {
		in_word_t word;
		bit       drain_first;
	} queued_word_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	in_word_t  in_data = '0;
	logic      in_ready;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	queued_word_t word_queue[$];
	out_word_t    expected_results[$];
	queued_word_t next_word;
	out_word_t    want;
	bit           all_done = 1'b1;
	int           errors = 0;
	int           send_gap = 0;
	int           send_calm = 0;
	int           recv_stall = 0;
	int           recv_calm = 0;

	// Model of the table contents.
	logic [ADDR_W-1:0] slot_addr [ENTRIES];
	logic              slot_used [ENTRIES];

	neighbor_address_set_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Applies one word to the table model and returns the result it should produce.
	function automatic out_word_t table_apply(in_word_t w);
		out_word_t res;
		logic      dup;
		logic      room;
		logic      hit;
		int        idx;
		res = '0;
		dup = 1'b0;
		room = 1'b0;
		hit = 1'b0;
		idx = 0;
		if (w.command == CMD_ADD) begin
			// The highest free slot wins, so the last one seen is kept.
			for (int i = 0; i < ENTRIES; i++) begin
				if (!slot_used[i]) begin
					room = 1'b1;
					idx = i;
				end else if (slot_addr[i] == w.address) begin
					dup = 1'b1;
				end
			end
			if (dup) begin
				res.status = ST_PRESENT;
			end else if (!room) begin
				res.status = ST_FULL;
			end else begin
				slot_used[idx] = 1'b1;
				slot_addr[idx] = w.address;
				res.success = 1'b1;
				res.status = ST_ADDED;
				res.slot = idx[2:0];
			end
		end else begin
			// Walk downward so that the lowest matching slot is the one kept.
			for (int i = ENTRIES - 1; i >= 0; i--) begin
				if (slot_used[i] && slot_addr[i] == w.address) begin
					hit = 1'b1;
					idx = i;
				end
			end
			if (hit) begin
				slot_used[idx] = 1'b0;
				slot_addr[idx] = '0;
				res.success = 1'b1;
				res.status = ST_REMOVED;
				res.slot = idx[2:0];
			end else begin
				res.status = ST_NOT_FOUND;
			end
		end
		return res;
	endfunction

	task automatic check_field(string name, int exp_val, int got_val);
		if (exp_val != got_val) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val,
				got_val);
			errors++;
		end
	endtask

	task automatic enqueue_word(logic cmd, logic [ADDR_W-1:0] addr, bit drain);
		queued_word_t q;
		q.word.command = cmd;
		q.word.address = addr;
		q.drain_first = drain;
		word_queue.push_back(q);
	endtask

	// Driver: presents queued words, holds each until accepted, then idles at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap = 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (word_queue.size() == 0 ||
				(word_queue[0].drain_first && (in_valid || !all_done))) begin
				in_valid <= 1'b0;
			end else begin
				next_word = word_queue.pop_front();
				in_valid <= 1'b1;
				in_data <= next_word.word;
				if (send_calm > 0) begin
					send_calm--;
					send_gap = 0;
				end else begin
					send_gap = idle_len();
					if ($urandom_range(0, 39) == 0)
						send_calm = $urandom_range(20, 60);
				end
			end
		end
	end

	// Monitor: predicts on every accepted input word and checks every accepted result word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			all_done <= 1'b1;
			recv_stall = 0;
			for (int i = 0; i < ENTRIES; i++) begin
				slot_used[i] = 1'b0;
				slot_addr[i] = '0;
			end
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(table_apply(in_data));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result word with nothing expected: success %0d status %0d slot %0d",
						$time, out_data.success, out_data.status, out_data.slot);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("success", int'(want.success), int'(out_data.success));
					check_field("status", int'(want.status), int'(out_data.status));
					check_field("slot", int'(want.slot), int'(out_data.slot));
				end
			end
			all_done <= (expected_results.size() == 0);
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (recv_calm > 0) begin
					recv_calm--;
				end else begin
					recv_stall = idle_len();
					if ($urandom_range(0, 39) == 0)
						recv_calm = $urandom_range(20, 60);
				end
			end
		end
	end

	initial begin
		logic [ADDR_W-1:0] pool [12];
		int                phase;
		int                r;
		logic              cmd;
		logic [ADDR_W-1:0] addr;

		// Directed part. Freed entries hold address zero and must never match.
		enqueue_word(CMD_REMOVE, 32'h0000_0000, 1'b0);
		enqueue_word(CMD_ADD, 32'h0000_0000, 1'b0);
		enqueue_word(CMD_ADD, 32'h0000_0000, 1'b0);
		enqueue_word(CMD_ADD, 32'hFFFF_FFFF, 1'b0);
		enqueue_word(CMD_ADD, 32'hA5A5_A5A5, 1'b0);
		enqueue_word(CMD_ADD, 32'h5A5A_5A5A, 1'b0);
		enqueue_word(CMD_ADD, 32'h1234_5678, 1'b0);
		enqueue_word(CMD_ADD, 32'h8000_0000, 1'b0);
		enqueue_word(CMD_ADD, 32'h0000_0001, 1'b0);
		enqueue_word(CMD_ADD, 32'h7FFF_FFFF, 1'b0);
		enqueue_word(CMD_ADD, 32'hDEAD_BEEF, 1'b0);
		enqueue_word(CMD_ADD, 32'hFFFF_FFFF, 1'b0);
		enqueue_word(CMD_REMOVE, 32'h8000_0000, 1'b1);
		enqueue_word(CMD_REMOVE, 32'h8000_0000, 1'b0);
		enqueue_word(CMD_ADD, 32'hCAFE_F00D, 1'b0);
		enqueue_word(CMD_REMOVE, 32'h0000_0000, 1'b0);
		enqueue_word(CMD_REMOVE, 32'h0000_0000, 1'b0);
		enqueue_word(CMD_ADD, 32'h0000_0001, 1'b0);
		enqueue_word(CMD_ADD, 32'h0000_0000, 1'b0);
		enqueue_word(CMD_REMOVE, 32'h7FFF_FFFF, 1'b0);
		enqueue_word(CMD_REMOVE, 32'hFFFF_FFFF, 1'b0);
		enqueue_word(CMD_ADD, 32'h0000_0002, 1'b0);

		// Random part: fill, drain and mixed phases over a small address pool, so that
		// duplicates, full-table adds and hits on removal are common.
		for (int k = 0; k < 12; k++)
			pool[k] = $urandom;
		for (int n = 0; n < 720; n++) begin
			if (n % 120 == 0) begin
				for (int k = 0; k < 12; k++)
					enqueue_word(CMD_REMOVE, pool[k], 1'b0);
				for (int k = 0; k < 12; k++) begin
					r = $urandom_range(0, 15);
					pool[k] = (r == 0) ? '0 : (r == 1) ? '1 : ADDR_W'($urandom);
				end
			end
			phase = (n / 40) % 3;
			r = $urandom_range(0, 99);
			if (phase == 0)
				cmd = (r < 80) ? CMD_ADD : CMD_REMOVE;
			else if (phase == 1)
				cmd = (r < 20) ? CMD_ADD : CMD_REMOVE;
			else
				cmd = (r < 50) ? CMD_ADD : CMD_REMOVE;
			if ($urandom_range(0, 9) == 0)
				addr = $urandom;
			else
				addr = pool[$urandom_range(0, 11)];
			enqueue_word(cmd, addr, n % 250 == 249);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Sample after the edge so that the driver and the monitor have settled.
		do begin
			@(posedge clk);
			#1;
		end while (!(word_queue.size() == 0 && !in_valid && all_done));
		repeat (3 * (ENTRIES + 1) + 10) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: %0d result words never arrived", $time, expected_results.size());
			errors++;
		end
		if (errors == 0)
			$display("tb_neighbor_address_set_core: done, clean");
		else
			$display("tb_neighbor_address_set_core: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout", $time);
		$display("tb_neighbor_address_set_core: done, errors");
		$finish;
	end

endmodule
